FILE: rtl/core/gbl_pkg.sv
package gbl_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;
    localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

    localparam int ACT_W      = 2;
    localparam int RAW_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int BIAS_W     = 24;
    localparam int LPF_W      = 25;
    localparam int OUT_W      = 25;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 16;
    localparam int ALPHA_W    = 16;
    localparam int DEAD_W     = 23;
    localparam int DIFF_W     = LPF_W + 1;
    localparam int PROD_W     = ALPHA_W + 1 + DIFF_W;
    localparam int SHIFT_W    = 16;

    localparam int DIV_W      = SUM_W + FRAC_W;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DEAD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd2;

    localparam logic [CNT_W-1:0]   RST_CALIB_COUNT = 16'd200;
    localparam logic [ALPHA_W-1:0] RST_SMOOTHING   = 16'd9830;
    localparam logic [DEAD_W-1:0]  RST_DEAD_ZONE   = 23'd5033;

    localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CAL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILT  = 2'd2;

    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_BIAS = 1'b1;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

FILE: rtl/core/gbl_smp_if.sv
interface gbl_smp_if import gbl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [RAW_W-1:0]  rate_x;
    logic signed [RAW_W-1:0]  rate_y;
    logic signed [RAW_W-1:0]  rate_z;

    modport source (output valid, output action, output rate_x, output rate_y,
                    output rate_z, input ready);
    modport sink (input valid, input action, input rate_x, input rate_y,
                  input rate_z, output ready);
endinterface

FILE: rtl/core/gbl_res_if.sv
interface gbl_res_if import gbl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [OUT_W-1:0]  out_x;
    logic signed [OUT_W-1:0]  out_y;
    logic signed [OUT_W-1:0]  out_z;

    modport source (output valid, output kind, output out_x, output out_y,
                    output out_z, input ready);
    modport sink (input valid, input kind, input out_x, input out_y,
                  input out_z, output ready);
endinterface

FILE: rtl/core/gbl_div.sv
module gbl_div import gbl_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [SUM_W-1:0]   i_num,
    input  logic [CNT_W-1:0]          i_den,
    output logic                      o_done,
    output logic signed [BIAS_W-1:0]  o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_neg;
    logic [DIV_W-1:0]      r_mag;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_den;
    logic [BIAS_W-1:0]     r_quo;

    logic [SUM_W-1:0]      w_mag;
    logic [CNT_W:0]        w_shift;
    logic [CNT_W:0]        w_diff;
    logic                  w_ge;

    assign w_mag   = i_num[SUM_W-1] ? (~i_num + 1'b1) : i_num;
    assign w_shift = {r_rem, r_mag[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= {w_mag, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[SUM_W-1];
            r_den <= i_den;
        end else if (r_busy) begin
            r_mag <= {r_mag[DIV_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_quo <= {r_quo[BIAS_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -r_quo : r_quo;

endmodule

FILE: rtl/core/gbl_lpf.sv
module gbl_lpf import gbl_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic signed [RAW_W-1:0]   i_raw,
    input  logic signed [BIAS_W-1:0]  i_bias,
    input  logic signed [LPF_W-1:0]   i_state,
    input  logic [ALPHA_W-1:0]        i_alpha,
    input  logic [DEAD_W-1:0]         i_dead,
    output logic signed [LPF_W-1:0]   o_next,
    output logic signed [OUT_W-1:0]   o_res
);

    logic signed [DIFF_W-1:0]  w_x;
    logic signed [DIFF_W-1:0]  w_b;
    logic signed [DIFF_W-1:0]  w_s;
    logic signed [DIFF_W-1:0]  w_d;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [LPF_W-1:0]   r_step;
    logic [LPF_W-1:0]          w_mag;

    assign w_x    = {{(DIFF_W-RAW_W-FRAC_W){i_raw[RAW_W-1]}}, i_raw, {FRAC_W{1'b0}}};
    assign w_b    = {{(DIFF_W-BIAS_W){i_bias[BIAS_W-1]}}, i_bias};
    assign w_s    = {{(DIFF_W-LPF_W){i_state[LPF_W-1]}}, i_state};
    assign w_d    = w_x - w_b - w_s;
    assign w_prod = $signed({1'b0, i_alpha}) * w_d;

    // floor shift: keep the bits that survive the wrap to the state width
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_step <= w_prod[SHIFT_W+LPF_W-1:SHIFT_W];
        end
    end

    assign o_next = i_state + r_step;
    assign w_mag  = o_next[LPF_W-1] ? LPF_W'(-o_next) : o_next;
    assign o_res  = (w_mag < {{(LPF_W-DEAD_W){1'b0}}, i_dead}) ? '0 : o_next;

endmodule

FILE: rtl/core/gyro_bias_lpf_deadband_unit.sv
// Channel  | Dir | Payload                        | Handshake
// i_smp    | in  | action, rate_x/y/z             | valid/ready
// o_res    | out | kind, out_x/y/z                | valid/ready
// i_cfg_*  | in  | idx, data                      | write enable only
//
// Begin calibration, ignored codes and non-final calibration samples: S_EXEC, then back to S_IDLE.
// Filter sample: three axes in turn through one shared multiply stage.
// Final calibration sample: three 40-step divisions in turn on one divider.
// Reset: synchronous, active low; no clearing pass.
// A finished result waits in the output register; the next transaction is taken meanwhile.
module gyro_bias_lpf_deadband_unit import gbl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gbl_smp_if.sink                i_smp,
    gbl_res_if.source              o_res,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_DSTART = 7'b0000100,
        S_DWAIT  = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_ACC    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_calib;
    logic [ALPHA_W-1:0]        r_smooth;
    logic [DEAD_W-1:0]         r_dead;
    logic [AXIS_W-1:0]         r_axis;
    logic [CNT_W-1:0]          r_count;
    logic [ACT_W-1:0]          r_act;
    logic signed [RAW_W-1:0]   r_raw  [AXES];
    logic signed [SUM_W-1:0]   r_sum  [AXES];
    logic signed [BIAS_W-1:0]  r_bias [AXES];
    logic signed [LPF_W-1:0]   r_lpf  [AXES];
    logic signed [OUT_W-1:0]   r_res  [AXES];
    logic                      r_kind;
    logic                      r_ovalid;
    logic                      r_okind;
    logic signed [OUT_W-1:0]   r_oval [AXES];

    logic [CNT_W-1:0]          w_target;
    logic [CNT_W-1:0]          n_count;
    logic                      w_acc;
    logic                      w_load;
    t_div_ctl                  w_div;
    logic signed [BIAS_W-1:0]  w_quot;
    logic signed [LPF_W-1:0]   w_next;
    logic signed [OUT_W-1:0]   w_fres;

    assign w_target  = (r_calib == '0) ? CNT_W'(1) : r_calib;
    assign n_count   = r_count + 1'b1;
    assign w_acc     = (r_state == S_IDLE) && i_smp.valid;
    assign w_load    = (r_state == S_OUT) && (!r_ovalid || o_res.ready);
    assign w_div.start = (r_state == S_DSTART);

    gbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div.start),
        .i_num   (r_sum[r_axis]),
        .i_den   (r_count),
        .o_done  (w_div.done),
        .o_quot  (w_quot)
    );

    gbl_lpf u_lpf (
        .i_clk   (i_clk),
        .i_load  (r_state == S_MUL),
        .i_raw   (r_raw[r_axis]),
        .i_bias  (r_bias[r_axis]),
        .i_state (r_lpf[r_axis]),
        .i_alpha (r_smooth),
        .i_dead  (r_dead),
        .o_next  (w_next),
        .o_res   (w_fres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_calib  <= RST_CALIB_COUNT;
            r_smooth <= RST_SMOOTHING;
            r_dead   <= RST_DEAD_ZONE;
            r_axis   <= AXIS_FIRST;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
                r_lpf[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CALIB_COUNT: r_calib  <= i_cfg_data[CNT_W-1:0];
                    CFG_SMOOTHING:   r_smooth <= i_cfg_data[ALPHA_W-1:0];
                    CFG_DEAD_ZONE:   r_dead   <= i_cfg_data[DEAD_W-1:0];
                    default: ;
                endcase
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_axis <= AXIS_FIRST;
                    case (r_act)
                        ACT_BEGIN: begin
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i]  <= '0;
                                r_bias[i] <= '0;
                            end
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end
                        ACT_CAL: begin
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i] <= r_sum[i]
                                    + {{(SUM_W-RAW_W){r_raw[i][RAW_W-1]}}, r_raw[i]};
                            end
                            r_count <= n_count;
                            r_state <= (n_count >= w_target) ? S_DSTART : S_IDLE;
                        end
                        ACT_FILT: r_state <= S_MUL;
                        default:  r_state <= S_IDLE;
                    endcase
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div.done) begin
                        r_bias[r_axis] <= w_quot;
                        if (r_axis == AXIS_LAST) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_sum[i] <= '0;
                            end
                            r_count <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_lpf[r_axis] <= w_next;
                    if (r_axis == AXIS_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act    <= i_smp.action;
            r_raw[0] <= i_smp.rate_x;
            r_raw[1] <= i_smp.rate_y;
            r_raw[2] <= i_smp.rate_z;
        end
        if ((r_state == S_DWAIT) && w_div.done) begin
            r_res[r_axis] <= {w_quot[BIAS_W-1], w_quot};
            r_kind        <= KIND_BIAS;
        end
        if (r_state == S_ACC) begin
            r_res[r_axis] <= w_fres;
            r_kind        <= KIND_RATE;
        end
        if (w_load) begin
            r_okind <= r_kind;
            for (int i = 0; i < AXES; i++) begin
                r_oval[i] <= r_res[i];
            end
        end
    end

    assign i_smp.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.kind  = r_okind;
    assign o_res.out_x = r_oval[0];
    assign o_res.out_y = r_oval[1];
    assign o_res.out_z = r_oval[2];

endmodule

FILE: rtl/core/gbl_chk.sv
module gbl_chk import gbl_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic                     i_out_kind,
    input logic signed [OUT_W-1:0]  i_out_x,
    input logic signed [OUT_W-1:0]  i_out_y,
    input logic signed [OUT_W-1:0]  i_out_z
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_z))
        else $error("result payload changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction taken while one is in progress");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result raised one cycle after input transaction");

    a_bias_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_BIAS) |->
            (i_out_x[OUT_W-1] == i_out_x[OUT_W-2]) &&
            (i_out_y[OUT_W-1] == i_out_y[OUT_W-2]) &&
            (i_out_z[OUT_W-1] == i_out_z[OUT_W-2]))
        else $error("bias report exceeds bias width");

endmodule

bind gyro_bias_lpf_deadband_unit gbl_chk u_gbl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z)
);

FILE: sim/gyro_bias_lpf_deadband_unit_test.sv
`timescale 1ns / 100ps

import gbl_pkg::*;

typedef struct packed {
    logic                    kind;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
} t_gyro_out;

class gyro_rate_board;
    logic [CNT_W-1:0]   calib_target;
    logic [ALPHA_W-1:0] alpha;
    logic [DEAD_W-1:0]  dead_zone;
    longint             lpf[AXES];
    longint             bias[AXES];
    longint             sum[AXES];
    int unsigned        taken;
    t_gyro_out          pending[$];
    int                 mismatches;

    function new();
        calib_target = RST_CALIB_COUNT;
        alpha        = RST_SMOOTHING;
        dead_zone    = RST_DEAD_ZONE;
        foreach (lpf[i]) begin
            lpf[i]  = 0;
            bias[i] = 0;
            sum[i]  = 0;
        end
        taken      = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CALIB_COUNT: calib_target = data[CNT_W-1:0];
            CFG_SMOOTHING:   alpha        = data[ALPHA_W-1:0];
            CFG_DEAD_ZONE:   dead_zone    = data[DEAD_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_sample(logic [ACT_W-1:0] act, logic signed [RAW_W-1:0] rx,
                              logic signed [RAW_W-1:0] ry, logic signed [RAW_W-1:0] rz);
        longint                   raw[AXES];
        logic signed [OUT_W-1:0]  val[AXES];
        logic signed [BIAS_W-1:0] b24;
        logic signed [LPF_W-1:0]  f25;
        longint                   nxt;
        longint                   mag;
        int unsigned              target;
        t_gyro_out                entry;
        raw[0] = rx;
        raw[1] = ry;
        raw[2] = rz;
        case (act)
            ACT_BEGIN: begin
                foreach (bias[i]) begin
                    bias[i] = 0;
                    sum[i]  = 0;
                end
                taken = 0;
            end
            ACT_CAL: begin
                target = (calib_target == '0) ? 1 : calib_target;
                foreach (sum[i])
                    sum[i] += raw[i];
                taken = (taken + 1) & 32'hFFFF;
                if (taken >= target) begin
                    foreach (sum[i]) begin
                        nxt     = (sum[i] * 256) / longint'(taken);
                        b24     = nxt[BIAS_W-1:0];
                        bias[i] = b24;
                        val[i]  = b24;
                        sum[i]  = 0;
                    end
                    taken      = 0;
                    entry.kind = KIND_BIAS;
                    entry.x    = val[0];
                    entry.y    = val[1];
                    entry.z    = val[2];
                    pending.push_back(entry);
                end
            end
            ACT_FILT: begin
                foreach (lpf[i]) begin
                    nxt    = raw[i] * 256 - bias[i] - lpf[i];
                    nxt    = lpf[i] + ((longint'(alpha) * nxt) >>> 16);
                    f25    = nxt[LPF_W-1:0];
                    lpf[i] = f25;
                    mag    = (lpf[i] < 0) ? -lpf[i] : lpf[i];
                    val[i] = (mag < longint'(dead_zone)) ? '0 : f25;
                end
                entry.kind = KIND_RATE;
                entry.x    = val[0];
                entry.y    = val[1];
                entry.z    = val[2];
                pending.push_back(entry);
            end
            default: ;
        endcase
    endfunction

    function void check_output(t_gyro_out got);
        t_gyro_out want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output: kind=%0d x=%0d y=%0d z=%0d",
                         got.kind, $signed(got.x), $signed(got.y), $signed(got.z));
            return;
        end
        want = pending.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp kind=%0d x=%0d y=%0d z=%0d got kind=%0d x=%0d y=%0d z=%0d",
                         want.kind, $signed(want.x), $signed(want.y), $signed(want.z),
                         got.kind, $signed(got.x), $signed(got.y), $signed(got.z));
        end
    endfunction
endclass

module gyro_bias_lpf_deadband_unit_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 85;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 300;
    localparam int RATE_MAX    = 32767;
    localparam int RATE_MIN    = -32768;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm         = 1'b0;
    bit                    hold_request = 1'b0;
    int                    items_sent   = 0;
    int unsigned           cycles       = 0;
    gyro_rate_board        board;

    gbl_smp_if smp ();
    gbl_res_if res ();

    gyro_bias_lpf_deadband_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4;
        clk = 1'b1;
        #4;
        clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res.valid && res.ready)
                board.check_output({res.kind, res.out_x, res.out_y, res.out_z});
            if (smp.valid && smp.ready)
                board.take_sample(smp.action, smp.rate_x, smp.rate_y, smp.rate_z);
            if (cfg_we)
                board.write_reg(cfg_idx, cfg_data);
        end
    end

    // result side: short random stalls, or one long hold on request
    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                res.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res.ready <= 1'b1;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [ACT_W-1:0] act, input int rx, input int ry,
                               input int rz);
        if (!calm && $urandom_range(0, 3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        smp.valid  <= 1'b1;
        smp.action <= act;
        smp.rate_x <= rx[RAW_W-1:0];
        smp.rate_y <= ry[RAW_W-1:0];
        smp.rate_z <= rz[RAW_W-1:0];
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
        if (act != ACT_SPARE)
            items_sent++;
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] count, input logic [ALPHA_W-1:0] a,
                             input logic [DEAD_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CALIB_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_idx  <= CFG_SMOOTHING;
        cfg_data <= a;
        @(posedge clk);
        cfg_idx  <= CFG_DEAD_ZONE;
        cfg_data <= d;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic int pick_rate(int centre);
        logic signed [RAW_W-1:0] r;
        int                      v;
        r = RAW_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
            1, 2:    v = r;
            default: v = centre + int'($urandom_range(0, 600)) - 300;
        endcase
        if (v > RATE_MAX)
            v = RATE_MAX;
        if (v < RATE_MIN)
            v = RATE_MIN;
        return v;
    endfunction

    initial begin
        int               centre;
        int               ncal;
        int               eff;
        int               stop_at;
        logic [ACT_W-1:0] act;
        logic [CNT_W-1:0] count;
        logic [ALPHA_W-1:0] a;
        logic [DEAD_W-1:0]  d;
        board      = new();
        smp.valid  = 1'b0;
        smp.action = ACT_BEGIN;
        smp.rate_x = '0;
        smp.rate_y = '0;
        smp.rate_z = '0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_CALIB_COUNT;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // filter before any calibration, reset register values
        send_sample(ACT_FILT, RATE_MAX, RATE_MIN, 0);
        send_sample(ACT_FILT, RATE_MIN, RATE_MAX, 1);
        send_sample(ACT_FILT, 0, -1, 300);
        send_sample(ACT_SPARE, -1, -1, -1);
        drain();
        configure(CNT_W'(3), '1, '0);
        send_sample(ACT_BEGIN, 0, 0, 0);
        send_sample(ACT_CAL, RATE_MIN, RATE_MAX, 5);
        send_sample(ACT_CAL, RATE_MIN, RATE_MAX, -7);
        send_sample(ACT_CAL, RATE_MIN, RATE_MAX, 1);
        send_sample(ACT_FILT, RATE_MAX, RATE_MIN, 0);
        send_sample(ACT_FILT, 0, 0, 0);
        // restart mid-round: bias cleared, filter kept
        send_sample(ACT_CAL, 100, 200, 300);
        send_sample(ACT_BEGIN, 0, 0, 0);
        send_sample(ACT_FILT, 1, 2, 3);
        drain();
        configure('0, '0, '1);
        send_sample(ACT_CAL, 10, -10, 3);
        send_sample(ACT_CAL, -5, 5, 7);
        send_sample(ACT_FILT, 1000, -1000, 0);
        drain();
        configure('1, 16'h8000, DEAD_W'(256));
        send_sample(ACT_BEGIN, 0, 0, 0);
        send_sample(ACT_CAL, 1000, -1000, 3);
        send_sample(ACT_CAL, 1001, -1001, -3);
        send_sample(ACT_CAL, 1002, -1002, 2);
        drain();
        // lower the count mid-round: next sample completes over four
        configure(CNT_W'(2), 16'h8000, DEAD_W'(256));
        send_sample(ACT_CAL, 999, -999, 4);
        send_sample(ACT_FILT, 1000, -1000, 3);
        send_sample(ACT_FILT, 1001, -1001, 2);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0:       count = '0;
                1:       count = CNT_W'(1);
                2:       count = '1;
                default: count = CNT_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       a = '0;
                1:       a = '1;
                default: a = ALPHA_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       d = '0;
                1:       d = '1;
                2:       d = DEAD_W'($urandom);
                default: d = DEAD_W'($urandom_range(0, 60000));
            endcase
            configure(count, a, d);
            calm = (phase == PHASES - 1);
            if (phase == 1)
                hold_request = 1'b1;
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                centre = int'($urandom_range(0, 40000)) - 20000;
                if ($urandom_range(0, 9) < 7) begin
                    eff  = (board.calib_target == '0) ? 1 : board.calib_target;
                    ncal = (eff <= 16) ? eff : $urandom_range(1, 8);
                    send_sample(ACT_BEGIN, pick_rate(centre), pick_rate(centre),
                                pick_rate(centre));
                    repeat (ncal)
                        send_sample(ACT_CAL, pick_rate(centre), pick_rate(centre),
                                    pick_rate(centre));
                    repeat ($urandom_range(2, 12))
                        send_sample(ACT_FILT, pick_rate(centre), pick_rate(centre),
                                    pick_rate(centre));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        act = ACT_W'($urandom_range(0, 3));
                        send_sample(act, pick_rate(centre), pick_rate(centre),
                                    pick_rate(centre));
                    end
                end
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
